// ===== src/remote_control_frame_parser_top_assert.svh =====
// Assertion macros for the remote control frame parser.
`ifndef REMOTE_CONTROL_FRAME_PARSER_TOP_ASSERT_SVH
`define REMOTE_CONTROL_FRAME_PARSER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define RCFP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define RCFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rcfp_pkg.sv =====
// Types, constants and the CRC-8 byte step for the remote control frame parser.
package rcfp_pkg;

  localparam int unsigned FrameLen  = 14;
  localparam int unsigned IdxW      = $clog2(FrameLen);
  localparam int unsigned LastIdx   = FrameLen - 1;
  localparam int unsigned CrcIdx    = 12;
  localparam int unsigned CrcLastIdx = 11;
  localparam int unsigned NumButtons = 9;

  localparam logic [7:0] HeaderReset = 8'hAA;
  localparam logic [7:0] TailReset   = 8'hBB;
  localparam logic [7:0] CrcPoly     = 8'h07;
  localparam logic [NumButtons-1:0] AlignKeep = 9'h010;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_GOOD     = 2'd0,
    STATUS_BAD_TAIL = 2'd1,
    STATUS_BAD_CRC  = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_HEADER = 2'd0,
    CFG_TAIL   = 2'd1,
    CFG_ALIGN  = 2'd2
  } cfg_idx_e;

  // Fold one byte into a CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/remote_control_frame_parser_top.sv =====
// Remote control frame parser: byte collector, running CRC-8 and result register.
//
// Input channel: rx_byte_i with rx_valid_i / rx_stall_o, one byte per request.
// Output channel: one decoded request per 14-byte frame on the *_o fields with
// out_valid_o / out_stall_i. Configuration: cfg_we_i, cfg_index_i, cfg_data_i.
// Bytes are dropped until one equals the header register; then 14 bytes are
// collected with no resync. The tail byte (byte 13) is checked first, then a
// CRC-8 over bytes 1..11 against byte 12. Bad frames report status only.
// Throughput: one byte per cycle unless stalled. The CRC is folded in byte
// by byte as the frame arrives, so the last byte needs only a tail and CRC
// compare. The registered result shows in the cycle after the last byte.
// Stall: while a result waits, bytes that do not close a frame are still
// taken; only the closing byte is held off until the result leaves.
// Reset: byte count, CRC, button history and output valid clear; header and
// tail registers return to 0xAA and 0xBB, align mode to off.
`include "remote_control_frame_parser_top_assert.svh"

module remote_control_frame_parser_top
  import rcfp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i,
  // byte input
  input  logic                  rx_valid_i,
  output logic                  rx_stall_o,
  input  logic [7:0]            rx_byte_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            frame_status_o,
  output logic signed [15:0]    left_x_o,
  output logic signed [15:0]    left_y_o,
  output logic signed [15:0]    right_x_o,
  output logic signed [15:0]    right_y_o,
  output logic                  left_stick_press_o,
  output logic                  right_stick_press_o,
  output logic [NumButtons-1:0] button_levels_o,
  output logic [NumButtons-1:0] release_events_o
);

  // Configuration registers
  logic [7:0] header_q;
  logic [7:0] tail_q;
  logic       align_q;

  // Frame state
  logic [IdxW-1:0]       fill_q, fill_d;
  logic [7:0]            crc_q, crc_d;
  logic [NumButtons-1:0] prev_buttons_q, prev_buttons_d;
  logic [7:0]            frame_q [FrameLen];

  // Result register
  logic                  out_valid_q, out_valid_d;
  logic [1:0]            status_q, status_d;
  logic [15:0]           lx_q, lx_d, ly_q, ly_d, rx_q, rx_d, ry_q, ry_d;
  logic                  lpress_q, lpress_d, rpress_q, rpress_d;
  logic [NumButtons-1:0] levels_q, levels_d, release_q, release_d;

  logic rx_accept;
  logic out_accept;
  logic last_byte;
  logic store_en;
  logic [NumButtons-1:0] levels_new;
  logic [NumButtons-1:0] released_new;

  // Hold off only the frame-closing byte while a result waits
  assign last_byte  = (fill_q == IdxW'(LastIdx));
  assign rx_stall_o = out_valid_q && out_stall_i && last_byte;
  assign rx_accept  = rx_valid_i && !rx_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;
  assign store_en   = rx_accept && !last_byte &&
                      ((fill_q != '0) || (rx_byte_i == header_q));

  // Decode the collected frame
  assign levels_new   = {frame_q[10][0], frame_q[11]};
  assign released_new = prev_buttons_q & ~levels_new &
                        (align_q ? AlignKeep : {NumButtons{1'b1}});

  // Next frame state and result
  always_comb begin
    fill_d         = fill_q;
    crc_d          = crc_q;
    prev_buttons_d = prev_buttons_q;
    out_valid_d    = out_valid_q && !out_accept;
    status_d       = status_q;
    lx_d           = lx_q;
    ly_d           = ly_q;
    rx_d           = rx_q;
    ry_d           = ry_q;
    lpress_d       = lpress_q;
    rpress_d       = rpress_q;
    levels_d       = levels_q;
    release_d      = release_q;

    if (store_en) begin
      fill_d = fill_q + 1'b1;
      if (fill_q == '0) begin
        crc_d = '0;
      end else if (fill_q <= IdxW'(CrcLastIdx)) begin
        crc_d = crc8_byte(crc_q, rx_byte_i);
      end
    end

    if (rx_accept && last_byte) begin
      fill_d      = '0;
      out_valid_d = 1'b1;
      lx_d        = '0;
      ly_d        = '0;
      rx_d        = '0;
      ry_d        = '0;
      lpress_d    = 1'b0;
      rpress_d    = 1'b0;
      levels_d    = '0;
      release_d   = '0;
      priority if (rx_byte_i != tail_q) begin
        status_d = STATUS_BAD_TAIL;
      end else if (crc_q != frame_q[CrcIdx]) begin
        status_d = STATUS_BAD_CRC;
      end else begin
        status_d       = STATUS_GOOD;
        lx_d           = {frame_q[1], frame_q[2]};
        ly_d           = {frame_q[3], frame_q[4]};
        rx_d           = {frame_q[5], frame_q[6]};
        ry_d           = {frame_q[7], frame_q[8]};
        lpress_d       = frame_q[9][0];
        rpress_d       = frame_q[9][1];
        levels_d       = levels_new;
        release_d      = released_new;
        prev_buttons_d = levels_new;
      end
    end
  end

  // Configuration writes; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
      tail_q   <= TailReset;
      align_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HEADER: header_q <= cfg_data_i;
        CFG_TAIL:   tail_q   <= cfg_data_i;
        CFG_ALIGN:  align_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q         <= '0;
      crc_q          <= '0;
      prev_buttons_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      fill_q         <= fill_d;
      crc_q          <= crc_d;
      prev_buttons_q <= prev_buttons_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Frame bytes and result payload
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      frame_q[fill_q] <= rx_byte_i;
    end
    status_q  <= status_d;
    lx_q      <= lx_d;
    ly_q      <= ly_d;
    rx_q      <= rx_d;
    ry_q      <= ry_d;
    lpress_q  <= lpress_d;
    rpress_q  <= rpress_d;
    levels_q  <= levels_d;
    release_q <= release_d;
  end

  assign out_valid_o         = out_valid_q;
  assign frame_status_o      = status_q;
  assign left_x_o            = lx_q;
  assign left_y_o            = ly_q;
  assign right_x_o           = rx_q;
  assign right_y_o           = ry_q;
  assign left_stick_press_o  = lpress_q;
  assign right_stick_press_o = rpress_q;
  assign button_levels_o     = levels_q;
  assign release_events_o    = release_q;

  // Checks
  `RCFP_ASSERT_SAME(a_fill_range, 1'b1, fill_q <= IdxW'(LastIdx), "byte count out of range")
  `RCFP_ASSERT_NEXT(a_close_gives_result, rx_accept && last_byte, out_valid_q && fill_q == '0, "closing byte gave no result")
  `RCFP_ASSERT_SAME(a_bad_is_blank, out_valid_q && status_q != STATUS_GOOD, lx_q == '0 && levels_q == '0 && release_q == '0, "bad frame carries data")
  `RCFP_ASSERT_SAME(a_release_disjoint, out_valid_q, (release_q & levels_q) == '0, "released button still pressed")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the remote control frame parser top level.
`timescale 1ns / 100ps

module tb
  import rcfp_pkg::*;
();

  // Register index that maps to no register; writes to it must be ignored.
  localparam logic [1:0] CfgSpare = 2'd3;
  // Cycles with no accepted request before the run is declared hung.
  localparam int unsigned StallLimit = 3000;
  // Receiver hold-off used to fill the block up and stall its input.
  localparam int unsigned LongHold = 300;

  typedef logic [7:0] frame_t [FrameLen];

  typedef enum logic [1:0] {
    FAULT_NONE,
    FAULT_TAIL,
    FAULT_CRC,
    FAULT_BOTH
  } fault_e;

  typedef struct packed {
    status_e              status;
    logic signed [15:0]   left_x;
    logic signed [15:0]   left_y;
    logic signed [15:0]   right_x;
    logic signed [15:0]   right_y;
    logic                 left_press;
    logic                 right_press;
    logic [NumButtons-1:0] levels;
    logic [NumButtons-1:0] released;
  } frame_result_t;

  // Frame decoder copy plus the queue of decoded frames still owed by the block.
  class rc_frame_checker;
    logic [7:0]            header_val;
    logic [7:0]            tail_val;
    logic                  align_on;
    int unsigned           fill;
    frame_t                bytes_seen;
    logic [NumButtons-1:0] last_buttons;
    frame_result_t         pending_frames[$];
    int unsigned           mismatches;

    function new();
      header_val   = HeaderReset;
      tail_val     = TailReset;
      align_on     = 1'b0;
      fill         = 0;
      last_buttons = '0;
      mismatches   = 0;
    endfunction

    // CRC-8 over bytes 1 to 11, MSB first, zero start, no final xor.
    static function logic [7:0] crc_of(frame_t f);
      logic [7:0] c;
      c = 8'h00;
      for (int i = 1; i <= CrcLastIdx; i++) begin
        c = c ^ f[i];
        for (int b = 0; b < 8; b++) begin
          c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
        end
      end
      return c;
    endfunction

    static function string fmt(frame_result_t r);
      return $sformatf("status=%0d lx=%0d ly=%0d rx=%0d ry=%0d lp=%0b rp=%0b lv=%03h rel=%03h",
                       r.status, r.left_x, r.left_y, r.right_x, r.right_y,
                       r.left_press, r.right_press, r.levels, r.released);
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        CFG_HEADER: header_val = data;
        CFG_TAIL:   tail_val = data;
        CFG_ALIGN:  align_on = data[0];
        default: ;
      endcase
    endfunction

    // Collect one accepted byte; decode the frame when the 14th byte lands.
    function void take_byte(logic [7:0] b);
      frame_result_t         r;
      logic [NumButtons-1:0] lv;
      if (fill == 0 && b != header_val) return;
      bytes_seen[fill] = b;
      fill++;
      if (fill < FrameLen) return;
      fill = 0;
      r = '0;
      if (bytes_seen[LastIdx] != tail_val) begin
        r.status = STATUS_BAD_TAIL;
      end else if (crc_of(bytes_seen) != bytes_seen[CrcIdx]) begin
        r.status = STATUS_BAD_CRC;
      end else begin
        lv            = {bytes_seen[10][0], bytes_seen[11]};
        r.status      = STATUS_GOOD;
        r.left_x      = {bytes_seen[1], bytes_seen[2]};
        r.left_y      = {bytes_seen[3], bytes_seen[4]};
        r.right_x     = {bytes_seen[5], bytes_seen[6]};
        r.right_y     = {bytes_seen[7], bytes_seen[8]};
        r.left_press  = bytes_seen[9][0];
        r.right_press = bytes_seen[9][1];
        r.levels      = lv;
        r.released    = last_buttons & ~lv;
        if (align_on) r.released = r.released & AlignKeep;
        last_buttons  = lv;
      end
      pending_frames.push_back(r);
    endfunction

    // Compare one accepted result with the oldest owed frame.
    function void check_frame(frame_result_t got);
      frame_result_t want;
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected frame result: %s", fmt(got));
        return;
      end
      want = pending_frames.pop_front();
      if (got.status !== want.status || got.left_x !== want.left_x ||
          got.left_y !== want.left_y || got.right_x !== want.right_x ||
          got.right_y !== want.right_y || got.left_press !== want.left_press ||
          got.right_press !== want.right_press || got.levels !== want.levels ||
          got.released !== want.released) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("frame mismatch: expected %s", fmt(want));
          $display("                actual   %s", fmt(got));
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [1:0]            cfg_index_i = '0;
  logic [7:0]            cfg_data_i = '0;
  logic                  rx_valid_i = 1'b0;
  logic                  rx_stall_o;
  logic [7:0]            rx_byte_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [1:0]            frame_status_o;
  logic signed [15:0]    left_x_o;
  logic signed [15:0]    left_y_o;
  logic signed [15:0]    right_x_o;
  logic signed [15:0]    right_y_o;
  logic                  left_stick_press_o;
  logic                  right_stick_press_o;
  logic [NumButtons-1:0] button_levels_o;
  logic [NumButtons-1:0] release_events_o;

  rc_frame_checker chk = new();
  logic [7:0]      cur_header = HeaderReset;
  logic [7:0]      cur_tail = TailReset;
  int              send_burst = 0;
  int              recv_burst = 0;
  int              hold_off_cycles = 0;
  int unsigned     idle_cycles = 0;

  remote_control_frame_parser_top DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .rx_valid_i          (rx_valid_i),
    .rx_stall_o          (rx_stall_o),
    .rx_byte_i           (rx_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .frame_status_o      (frame_status_o),
    .left_x_o            (left_x_o),
    .left_y_o            (left_y_o),
    .right_x_o           (right_x_o),
    .right_y_o           (right_y_o),
    .left_stick_press_o  (left_stick_press_o),
    .right_stick_press_o (right_stick_press_o),
    .button_levels_o     (button_levels_o),
    .release_events_o    (release_events_o)
  );

  // Generate a 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Draw a per-request wait, with occasional runs of back-to-back requests.
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Fill in header, CRC and tail, damaging the checked bytes as asked.
  function automatic void seal_frame(inout frame_t f, input fault_e fault);
    f[0]       = cur_header;
    f[CrcIdx]  = rc_frame_checker::crc_of(f);
    f[LastIdx] = cur_tail;
    if (fault == FAULT_CRC || fault == FAULT_BOTH) f[CrcIdx] ^= 8'($urandom_range(1, 255));
    if (fault == FAULT_TAIL || fault == FAULT_BOTH) f[LastIdx] ^= 8'($urandom_range(1, 255));
  endfunction

  // Offer one byte after a random gap and hold it until accepted.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(send_burst);
    repeat (gap) begin
      @(negedge clk_i);
      rx_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (rx_stall_o);
  endtask

  task automatic send_frame(input frame_t f, input int first, input int last);
    for (int i = first; i <= last; i++) send_byte(f[i]);
  endtask

  // Drop valid and wait until every owed frame has come out.
  task automatic settle();
    @(negedge clk_i);
    rx_valid_i <= 1'b0;
    while (chk.pending_frames.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    chk.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_phase(input logic [7:0] h, input logic [7:0] t, input logic [7:0] a);
    settle();
    write_reg(CFG_HEADER, h);
    write_reg(CFG_TAIL, t);
    write_reg(CFG_ALIGN, a);
    cur_header = h;
    cur_tail   = t;
  endtask

  // Send one mostly well-formed frame, with noise, damage or truncation now and then.
  task automatic random_frame();
    frame_t     f;
    fault_e     fault;
    int         pick;
    logic [7:0] nb;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        nb = 8'($urandom_range(0, 255));
        if (nb == cur_header) nb = ~nb;
        send_byte(nb);
      end
    end
    for (int i = 1; i <= CrcLastIdx; i++) begin
      case ($urandom_range(0, 9))
        0: f[i] = 8'h00;
        1: f[i] = 8'hFF;
        2: f[i] = 8'h80;
        3: f[i] = 8'h7F;
        default: f[i] = 8'($urandom_range(0, 255));
      endcase
    end
    pick = $urandom_range(0, 19);
    if (pick < 2) fault = FAULT_TAIL;
    else if (pick < 4) fault = FAULT_CRC;
    else if (pick == 4) fault = FAULT_BOTH;
    else fault = FAULT_NONE;
    seal_frame(f, fault);
    send_frame(f, 0, ($urandom_range(0, 33) == 0) ? LastIdx - 1 : LastIdx);
  endtask

  // Stall the result side per request; take a long hold-off when one is asked.
  initial begin
    int w;
    forever begin
      if (hold_off_cycles > 0) begin
        w = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        w = draw_wait(recv_burst);
      end
      repeat (w) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Watch both channels, check results and catch a hung run.
  always @(posedge clk_i) begin
    frame_result_t got;
    if (rst_ni) begin
      if (rx_valid_i && !rx_stall_o) chk.take_byte(rx_byte_i);
      if (out_valid_o && !out_stall_i) begin
        got.status      = status_e'(frame_status_o);
        got.left_x      = left_x_o;
        got.left_y      = left_y_o;
        got.right_x     = right_x_o;
        got.right_y     = right_y_o;
        got.left_press  = left_stick_press_o;
        got.right_press = right_stick_press_o;
        got.levels      = button_levels_o;
        got.released    = release_events_o;
        chk.check_frame(got);
      end
      if ((rx_valid_i && !rx_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Main sequence: directed frames, then randomized phases under several settings.
  initial begin
    frame_t f;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Extreme left stick values, all buttons pressed.
    f = '{8'h00, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF,
          8'h03, 8'h01, 8'hFF, 8'h00, 8'h00};
    seal_frame(f, FAULT_NONE);
    send_frame(f, 0, LastIdx);
    // Opposite left stick extremes, every button released.
    f = '{8'h00, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00,
          8'h00, 8'hFE, 8'h00, 8'h00, 8'h00};
    seal_frame(f, FAULT_NONE);
    send_frame(f, 0, LastIdx);
    // Noise while idle is dropped.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAB);
    // Bad tail, bad CRC, and both at once.
    seal_frame(f, FAULT_TAIL);
    send_frame(f, 0, LastIdx);
    seal_frame(f, FAULT_CRC);
    send_frame(f, 0, LastIdx);
    seal_frame(f, FAULT_BOTH);
    send_frame(f, 0, LastIdx);
    // Header value inside a frame is plain data.
    f = '{default: HeaderReset};
    seal_frame(f, FAULT_NONE);
    send_frame(f, 0, LastIdx);
    // Change the header mid-frame; the open frame completes as started.
    f = '{8'h00, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF0,
          8'h02, 8'h01, 8'h10, 8'h00, 8'h00};
    seal_frame(f, FAULT_NONE);
    send_frame(f, 0, 5);
    settle();
    write_reg(CFG_HEADER, 8'h5A);
    cur_header = 8'h5A;
    send_frame(f, 6, LastIdx);
    seal_frame(f, FAULT_NONE);
    send_frame(f, 0, LastIdx);

    // Randomized phases.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_phase(8'h00, 8'hFF, 8'h01);
        1: begin
          set_phase(8'hFF, 8'h00, 8'hFE);
          write_reg(CfgSpare, 8'hFF);
        end
        2: set_phase(HeaderReset, TailReset, 8'h01);
        3: set_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        4: set_phase(8'h55, 8'h55, 8'h00);
        5: set_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'h01);
        6: set_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        default: set_phase(HeaderReset, TailReset, 8'h00);
      endcase
      // Hold the receiver off so the block fills up and stalls its input.
      if (p == 2) hold_off_cycles = LongHold;
      repeat (18) random_frame();
    end

    settle();
    if (chk.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/rcfp_pkg.sv
src/remote_control_frame_parser_top.sv
tb/sv/tb.sv
